// ===== hw/rtl/qsl_pkg.sv =====
// shared types, constants and sort microprogram for the quicksort block
package qsl_pkg;

   localparam int DATA_W           = 32;
   localparam int MAX_ELEMENTS_DEF = 64;

   // microprogram steps
   typedef enum logic [4:0] {
      ST_HALT,
      ST_INIT,
      ST_INITW,
      ST_POP,
      ST_LOAD,
      ST_CHK,
      ST_PIV,
      ST_SCAN,
      ST_TEST,
      ST_TEST2,
      ST_SWP1,
      ST_SWP2,
      ST_INCB,
      ST_INCS,
      ST_FIN,
      ST_FCMP,
      ST_FW1,
      ST_FW2,
      ST_PR,
      ST_PRW,
      ST_PL,
      ST_PLW,
      ST_OUT
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NOSTART,
      CND_LT2,
      CND_SP0,
      CND_LOHI,
      CND_SCANEND,
      CND_NOTLESS,
      CND_SAME,
      CND_PIVNOTLESS,
      CND_SKIPR,
      CND_SKIPL
   } cond_type;

   typedef enum logic [1:0] {ADR_HI, ADR_SCAN, ADR_PLACE} adr_type;
   typedef enum logic [1:0] {WD_TMPA, WD_TMPB, WD_PIVOT} wsel_type;
   typedef enum logic [1:0] {PSH_NONE, PSH_ALL, PSH_RIGHT, PSH_LEFT} push_type;

   typedef struct packed {
      cond_type cond;
      step_type target;
      adr_type  adr;
      logic     mem_we;
      wsel_type wsel;
      logic     ld_bounds;
      logic     init_ptrs;
      logic     ld_pivot;
      logic     ld_tmpa;
      logic     ld_tmpb;
      logic     inc_scan;
      logic     inc_place;
      logic     pop;
      logic     clr_sp;
      logic     done;
      push_type push;
   } uword_type;

   // control store: one word per step, fall through unless the condition jumps
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      w = '0;
      case (s)
         ST_HALT: begin
            w.cond   = CND_NOSTART;
            w.target = ST_HALT;
            w.clr_sp = 1'b1;
         end
         ST_INIT: begin
            w.cond   = CND_LT2;
            w.target = ST_OUT;
         end
         ST_INITW: begin
            w.push = PSH_ALL;
         end
         ST_POP: begin
            w.cond   = CND_SP0;
            w.target = ST_OUT;
            w.pop    = 1'b1;
         end
         ST_LOAD: begin
            w.ld_bounds = 1'b1;
         end
         ST_CHK: begin
            w.cond      = CND_LOHI;
            w.target    = ST_POP;
            w.adr       = ADR_HI;
            w.init_ptrs = 1'b1;
         end
         ST_PIV: begin
            w.ld_pivot = 1'b1;
         end
         ST_SCAN: begin
            w.cond   = CND_SCANEND;
            w.target = ST_FIN;
            w.adr    = ADR_SCAN;
         end
         ST_TEST: begin
            w.cond    = CND_NOTLESS;
            w.target  = ST_INCS;
            w.ld_tmpa = 1'b1;
         end
         ST_TEST2: begin
            w.cond   = CND_SAME;
            w.target = ST_INCB;
            w.adr    = ADR_PLACE;
         end
         ST_SWP1: begin
            w.adr     = ADR_PLACE;
            w.mem_we  = 1'b1;
            w.wsel    = WD_TMPA;
            w.ld_tmpb = 1'b1;
         end
         ST_SWP2: begin
            w.adr    = ADR_SCAN;
            w.mem_we = 1'b1;
            w.wsel   = WD_TMPB;
         end
         ST_INCB: begin
            w.cond      = CND_ALWAYS;
            w.target    = ST_SCAN;
            w.inc_scan  = 1'b1;
            w.inc_place = 1'b1;
         end
         ST_INCS: begin
            w.cond     = CND_ALWAYS;
            w.target   = ST_SCAN;
            w.inc_scan = 1'b1;
         end
         ST_FIN: begin
            w.adr = ADR_PLACE;
         end
         ST_FCMP: begin
            w.cond    = CND_PIVNOTLESS;
            w.target  = ST_PR;
            w.ld_tmpb = 1'b1;
         end
         ST_FW1: begin
            w.adr    = ADR_PLACE;
            w.mem_we = 1'b1;
            w.wsel   = WD_PIVOT;
         end
         ST_FW2: begin
            w.adr    = ADR_HI;
            w.mem_we = 1'b1;
            w.wsel   = WD_TMPB;
         end
         ST_PR: begin
            w.cond   = CND_SKIPR;
            w.target = ST_PL;
         end
         ST_PRW: begin
            w.push = PSH_RIGHT;
         end
         ST_PL: begin
            w.cond   = CND_SKIPL;
            w.target = ST_POP;
         end
         ST_PLW: begin
            w.cond   = CND_ALWAYS;
            w.target = ST_POP;
            w.push   = PSH_LEFT;
         end
         ST_OUT: begin
            w.cond   = CND_ALWAYS;
            w.target = ST_HALT;
            w.done   = 1'b1;
         end
         default: begin
            w.cond   = CND_ALWAYS;
            w.target = ST_HALT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/qsl_seq.sv =====
// microcoded sort sequencer with range stack and partition datapath
module qsl_seq #(
   parameter int  MAX_ELEMENTS = qsl_pkg::MAX_ELEMENTS_DEF,
   localparam int IDX_W        = $clog2(MAX_ELEMENTS),
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1),
   localparam int SP_W         = IDX_W + 1,
   localparam int SDEPTH       = 1 << IDX_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [CNT_W-1:0]           elem_count,
   input  logic [qsl_pkg::DATA_W-1:0] mem_rdata,
   output logic                       done,
   output logic                       mem_we,
   output logic [IDX_W-1:0]           mem_addr,
   output logic [qsl_pkg::DATA_W-1:0] mem_wdata
);

   qsl_pkg::step_type  upc_ff, upc_in;
   qsl_pkg::uword_type uw;

   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] scan_ff, scan_in, place_ff, place_in;
   logic [qsl_pkg::DATA_W-1:0] pivot_ff, pivot_in, tmpa_ff, tmpa_in, tmpb_ff, tmpb_in;
   logic [SP_W-1:0]  sp_ff, sp_in, sp_m1;

   logic [2*IDX_W-1:0] stack_mem [SDEPTH];
   logic [2*IDX_W-1:0] stk_rd_ff;

   logic             cond_hit, rd_less, piv_less, push_en, pop_en;
   logic [IDX_W:0]   place_p1, lo_p1;
   logic [IDX_W-1:0] place_m1, push_lo, push_hi;
   logic [CNT_W-1:0] cnt_m1;

   always_comb begin
      uw       = qsl_pkg::ucode(upc_ff);
      rd_less  = $signed(mem_rdata) < $signed(pivot_ff);
      piv_less = $signed(pivot_ff) < $signed(mem_rdata);
      place_p1 = {1'b0, place_ff} + (IDX_W + 1)'(1);
      lo_p1    = {1'b0, lo_ff} + (IDX_W + 1)'(1);
      place_m1 = place_ff - IDX_W'(1);
      cnt_m1   = elem_count - CNT_W'(1);
      sp_m1    = sp_ff - SP_W'(1);

      case (uw.cond)
         qsl_pkg::CND_NEVER:      cond_hit = 1'b0;
         qsl_pkg::CND_ALWAYS:     cond_hit = 1'b1;
         qsl_pkg::CND_NOSTART:    cond_hit = !start;
         qsl_pkg::CND_LT2:        cond_hit = elem_count < CNT_W'(2);
         qsl_pkg::CND_SP0:        cond_hit = sp_ff == '0;
         qsl_pkg::CND_LOHI:       cond_hit = lo_ff >= hi_ff;
         qsl_pkg::CND_SCANEND:    cond_hit = scan_ff >= hi_ff;
         qsl_pkg::CND_NOTLESS:    cond_hit = !rd_less;
         qsl_pkg::CND_SAME:       cond_hit = place_ff == scan_ff;
         qsl_pkg::CND_PIVNOTLESS: cond_hit = !piv_less;
         qsl_pkg::CND_SKIPR:      cond_hit = !(place_p1 < {1'b0, hi_ff});
         qsl_pkg::CND_SKIPL:      cond_hit = !({1'b0, place_ff} > lo_p1);
         default:                 cond_hit = 1'b1;
      endcase

      upc_in = cond_hit ? uw.target : qsl_pkg::step_type'(upc_ff + 1'b1);

      case (uw.push)
         qsl_pkg::PSH_ALL: begin
            push_lo = '0;
            push_hi = cnt_m1[IDX_W-1:0];
         end
         qsl_pkg::PSH_RIGHT: begin
            push_lo = place_p1[IDX_W-1:0];
            push_hi = hi_ff;
         end
         qsl_pkg::PSH_LEFT: begin
            push_lo = lo_ff;
            push_hi = place_m1;
         end
         default: begin
            push_lo = lo_ff;
            push_hi = hi_ff;
         end
      endcase

      // a push onto a full stack is dropped
      push_en = (uw.push != qsl_pkg::PSH_NONE) && (sp_ff < SP_W'(SDEPTH));
      pop_en  = uw.pop && (sp_ff != '0);

      if (uw.clr_sp) begin
         sp_in = '0;
      end else if (push_en) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (pop_en) begin
         sp_in = sp_m1;
      end else begin
         sp_in = sp_ff;
      end

      lo_in    = uw.ld_bounds ? stk_rd_ff[IDX_W-1:0] : lo_ff;
      hi_in    = uw.ld_bounds ? stk_rd_ff[2*IDX_W-1:IDX_W] : hi_ff;
      scan_in  = uw.init_ptrs ? lo_ff : (uw.inc_scan ? scan_ff + IDX_W'(1) : scan_ff);
      place_in = uw.init_ptrs ? lo_ff : (uw.inc_place ? place_p1[IDX_W-1:0] : place_ff);
      pivot_in = uw.ld_pivot ? mem_rdata : pivot_ff;
      tmpa_in  = uw.ld_tmpa ? mem_rdata : tmpa_ff;
      tmpb_in  = uw.ld_tmpb ? mem_rdata : tmpb_ff;

      case (uw.adr)
         qsl_pkg::ADR_HI:    mem_addr = hi_ff;
         qsl_pkg::ADR_SCAN:  mem_addr = scan_ff;
         qsl_pkg::ADR_PLACE: mem_addr = place_ff;
         default:            mem_addr = hi_ff;
      endcase

      case (uw.wsel)
         qsl_pkg::WD_TMPA:  mem_wdata = tmpa_ff;
         qsl_pkg::WD_TMPB:  mem_wdata = tmpb_ff;
         qsl_pkg::WD_PIVOT: mem_wdata = pivot_ff;
         default:           mem_wdata = tmpb_ff;
      endcase

      mem_we = uw.mem_we;
      done   = uw.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= qsl_pkg::ST_HALT;
         sp_ff  <= '0;
      end else begin
         upc_ff <= upc_in;
         sp_ff  <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      scan_ff  <= scan_in;
      place_ff <= place_in;
      pivot_ff <= pivot_in;
      tmpa_ff  <= tmpa_in;
      tmpb_ff  <= tmpb_in;
   end

   // range stack: top entry is read ahead into a register so a pop has it in the next step
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[sp_ff[IDX_W-1:0]] <= {push_hi, push_lo};
      end
      stk_rd_ff <= stack_mem[sp_m1[IDX_W-1:0]];
   end

endmodule

// ===== hw/rtl/quicksort_lomuto.sv =====
// top level of the collect, sort and emit quicksort block
// Values arrive one per transaction and are written into the element memory at one
// per cycle; the transaction with tlast closes the set and starts the sort. Up to
// MAX_ELEMENTS values are kept, later ones are dropped and every result of that set
// then carries tuser high. The sort is a Lomuto quicksort run by a microcoded
// sequencer over a memory with one write and one registered read port: each scanned
// element is read and compared with the pivot, one below the pivot is exchanged into
// the place position unless it is already there, and each range also needs stack
// handling and final placement of the pivot. Results then leave in ascending order,
// the last one with tlast, while the consumer is ready; a new read is issued only
// after the previous one has returned. Input is accepted again as soon as the read
// of the final result is issued. No clearing pass follows reset.
module quicksort_lomuto #(
   parameter int  MAX_ELEMENTS = qsl_pkg::MAX_ELEMENTS_DEF,
   localparam int IDX_W        = $clog2(MAX_ELEMENTS),
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [qsl_pkg::DATA_W-1:0] req_tdata,   // value [31:0]
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [qsl_pkg::DATA_W-1:0] rsp_tdata,   // sorted_value [31:0]
   output logic                       rsp_tlast,
   output logic                       rsp_tuser    // overflow [0]
);

   typedef enum logic [1:0] {PH_COLLECT, PH_SORT, PH_EMIT} state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             pend_ff, pend_in;
   logic             pend_final_ff, pend_final_in;
   logic             pend_ovf_ff, pend_ovf_in;
   logic             out_valid_ff, out_valid_in;
   logic [qsl_pkg::DATA_W-1:0] out_data_ff, out_data_in;
   logic             out_final_ff, out_final_in;
   logic             out_ovf_ff, out_ovf_in;

   logic [qsl_pkg::DATA_W-1:0] elem_mem [MAX_ELEMENTS];
   logic [qsl_pkg::DATA_W-1:0] rdata_ff;

   logic                       acc, room, issue, is_final;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr, mem_raddr;
   logic [qsl_pkg::DATA_W-1:0] mem_wdata;

   logic                       seq_done, seq_we;
   logic [IDX_W-1:0]           seq_addr;
   logic [qsl_pkg::DATA_W-1:0] seq_wdata;

   qsl_seq #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == PH_SORT),
      .elem_count (count_ff),
      .mem_rdata  (rdata_ff),
      .done       (seq_done),
      .mem_we     (seq_we),
      .mem_addr   (seq_addr),
      .mem_wdata  (seq_wdata)
   );

   always_comb begin
      req_tready = state_ff == PH_COLLECT;
      acc        = req_tvalid && req_tready;
      room       = count_ff < CNT_W'(MAX_ELEMENTS);
      issue      = (state_ff == PH_EMIT) && !pend_ff && (!out_valid_ff || rsp_tready);
      is_final   = CNT_W'(k_ff) == (count_ff - CNT_W'(1));

      if (state_ff == PH_COLLECT) begin
         mem_we    = acc && room;
         mem_waddr = count_ff[IDX_W-1:0];
         mem_wdata = req_tdata;
      end else begin
         mem_we    = seq_we;
         mem_waddr = seq_addr;
         mem_wdata = seq_wdata;
      end
      mem_raddr = (state_ff == PH_EMIT) ? k_ff : seq_addr;

      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      k_in          = k_ff;
      pend_in       = issue;
      pend_final_in = pend_final_ff;
      pend_ovf_in   = pend_ovf_ff;

      case (state_ff)
         PH_COLLECT: begin
            if (acc) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = PH_SORT;
               end
            end
         end
         PH_SORT: begin
            if (seq_done) begin
               state_in = PH_EMIT;
               k_in     = '0;
            end
         end
         PH_EMIT: begin
            if (issue) begin
               pend_final_in = is_final;
               pend_ovf_in   = dropped_ff;
               k_in          = k_ff + IDX_W'(1);
               if (is_final) begin
                  state_in   = PH_COLLECT;
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = PH_COLLECT;
         end
      endcase

      // output register: loaded in the cycle after its read was issued, when the read data arrives
      if (pend_ff) begin
         out_valid_in = 1'b1;
         out_data_in  = rdata_ff;
         out_final_in = pend_final_ff;
         out_ovf_in   = pend_ovf_ff;
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
         out_data_in  = out_data_ff;
         out_final_in = out_final_ff;
         out_ovf_in   = out_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      pend_final_ff <= pend_final_in;
      pend_ovf_ff   <= pend_ovf_in;
      out_data_ff   <= out_data_in;
      out_final_ff  <= out_final_in;
      out_ovf_ff    <= out_ovf_in;
      if (reset) begin
         state_ff     <= PH_COLLECT;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         elem_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= elem_mem[mem_raddr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_final_ff;
   assign rsp_tuser  = out_ovf_ff;

   a_pend_slot_free: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !out_valid_ff)
      else $error("read data arrived while the output register was still occupied");

   a_done_in_sort: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (state_ff == PH_SORT))
      else $error("sequencer finished outside the sort phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count above capacity");

   a_final_returns: assert property (@(posedge clock) disable iff (reset)
      (issue && is_final) |=> (state_ff == PH_COLLECT) && (count_ff == '0))
      else $error("set not closed after the final transaction was issued");

endmodule
